// ===== rtl/rlle_pkg.sv =====
// shared constants and types of the run/literal byte encoder
// no dependencies; imported by every module of the block
package rlle_pkg;

  // longest literal, longest run, result word size in bytes
  localparam int LIT_LIMIT = 128;
  localparam int RUN_LIMIT = 129;
  localparam int OUT_BYTES = 8;

  localparam int LIT_AW  = $clog2(LIT_LIMIT);
  localparam int LIT_CW  = $clog2(LIT_LIMIT + 1);
  localparam int RUN_W   = $clog2(RUN_LIMIT + 1);
  localparam int OUT_CW  = $clog2(OUT_BYTES + 1);
  localparam int OUT_LW  = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;

  localparam logic [7:0] LIT_HDR_BASE = 8'h80;

  // source of the byte pushed into the packer
  typedef enum logic [2:0] {
    SEL_RUN_CNT,
    SEL_RUN_VAL,
    SEL_LIT_HDR,
    SEL_LIT_DATA,
    SEL_ZERO
  } byte_sel_e;

  typedef struct packed {
    logic      load_in;
    logic      run_inc;
    logic      add;
    logic      run_clear;
    logic      load_flush;
    logic      final_clear;
    logic      rd_start;
    logic      rd_next;
    byte_sel_e sel;
  } dp_cmd_t;

  typedef struct packed {
    logic run_mode;
    logic match;
    logic run_below;
    logic run_at_edge;
    logic emit_zero;
    logic rd_last;
    logic fin;
    logic term_en;
  } dp_status_t;

  typedef struct packed {
    logic push;
    logic done;
    logic fin;
  } pack_cmd_t;

  typedef struct packed {
    logic can_push;
    logic can_done;
  } pack_status_t;

endpackage

// ===== rtl/run_literal_length_encoder_core.sv =====
// top level of the run/literal byte encoder
// depends on rlle_pkg, rlle_dp, rlle_pack and rlle_ctrl
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   input    | in_valid_i/in_stall_o  | data_byte_i, final_byte_i
//   output   | out_valid_o/out_stall_i| out_word_o, out_count_o, run_end_o,
//            |                        | stream_done_o
//   config   | cfg_we_i               | cfg_wdata_i (append terminator)
//
// a transaction that emits nothing (a buffered byte or a run step) runs S_IDLE,
// S_STEP and S_FIN or S_LIT_HDR; encoded bytes go one push a cycle (one store
// read port) unless the packer holds them; a run break or stream end adds states
// reset clears all control state; the literal store has no reset and is read
// only where the current literal has written it
// a stalled output word is held while the next is gathered; the controller
// waits only when a word must leave while the output is still stalled
module run_literal_length_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_word_o,
  output logic [3:0]  out_count_o,
  output logic        run_end_o,
  output logic        stream_done_o
);
  import rlle_pkg::*;

  dp_cmd_t      dp_cmd;
  dp_status_t   dp_status;
  pack_cmd_t    pk_cmd;
  pack_status_t pk_status;
  logic [7:0]   enc_byte;

  // sequencer: walks each transaction through run, literal and flush steps
  rlle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .dp_i       (dp_status),
    .dp_o       (dp_cmd),
    .pk_i       (pk_status),
    .pk_o       (pk_cmd)
  );

  // segment state, literal store and byte selection
  rlle_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .cmd_i        (dp_cmd),
    .status_o     (dp_status),
    .byte_o       (enc_byte)
  );

  // packs encoded bytes into words and holds the output register
  rlle_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (pk_cmd),
    .byte_i        (enc_byte),
    .status_o      (pk_status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_word_o    (out_word_o),
    .out_count_o   (out_count_o),
    .run_end_o     (run_end_o),
    .stream_done_o (stream_done_o)
  );

endmodule

// ===== rtl/rlle_dp.sv =====
// encoder datapath: segment state, literal store, terminator register, byte mux
// depends on rlle_pkg; driven by rlle_ctrl, feeds rlle_pack
module rlle_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic [7:0]          data_byte_i,
  input  logic                final_byte_i,
  input  rlle_pkg::dp_cmd_t   cmd_i,
  output rlle_pkg::dp_status_t status_o,
  output logic [7:0]          byte_o
);
  import rlle_pkg::*;

  logic              term_en_q;
  logic [7:0]        in_byte_q;
  logic              fin_q;
  logic [LIT_CW-1:0] lit_len_q, lit_len_d;
  logic [7:0]        prev_q, prev_d;
  logic [1:0]        rep_q, rep_d;
  logic              run_mode_q, run_mode_d;
  logic [RUN_W-1:0]  run_len_q, run_len_d;
  logic [LIT_CW-1:0] emit_n_q, emit_n_d;
  logic [LIT_CW-1:0] rd_idx_q, rd_idx_d;

  logic [7:0]        lit_mem [LIT_LIMIT];
  logic [7:0]        rd_data_q;
  logic [LIT_AW-1:0] rd_addr;
  logic              rd_en;

  logic [1:0]        rep_new;
  logic [LIT_CW-1:0] lit_len_new;

  assign rep_new     = (lit_len_q != '0 && in_byte_q == prev_q) ? rep_q + 2'd1 : 2'd1;
  assign lit_len_new = lit_len_q + LIT_CW'(1);

  always_comb begin
    lit_len_d  = lit_len_q;
    prev_d     = prev_q;
    rep_d      = rep_q;
    run_mode_d = run_mode_q;
    run_len_d  = run_len_q;
    emit_n_d   = emit_n_q;
    rd_idx_d   = rd_idx_q;

    if (cmd_i.run_inc) begin
      run_len_d = run_len_q + RUN_W'(1);
    end
    if (cmd_i.add) begin
      prev_d = in_byte_q;
      if (rep_new == 2'd3) begin
        // triple found: earlier bytes go out as a literal, a run starts
        emit_n_d   = lit_len_q - LIT_CW'(2);
        lit_len_d  = '0;
        rep_d      = '0;
        run_mode_d = 1'b1;
        run_len_d  = RUN_W'(3);
      end else if (lit_len_new == LIT_CW'(LIT_LIMIT)) begin
        emit_n_d   = lit_len_new;
        lit_len_d  = '0;
        rep_d      = '0;
        run_mode_d = 1'b0;
        run_len_d  = '0;
      end else begin
        emit_n_d  = '0;
        lit_len_d = lit_len_new;
        rep_d     = rep_new;
      end
    end
    if (cmd_i.run_clear || cmd_i.final_clear) begin
      lit_len_d  = '0;
      rep_d      = '0;
      run_mode_d = 1'b0;
      run_len_d  = '0;
    end
    if (cmd_i.final_clear) begin
      prev_d = '0;
    end
    if (cmd_i.load_flush) begin
      emit_n_d = lit_len_q;
    end
    if (cmd_i.rd_start) begin
      rd_idx_d = LIT_CW'(1);
    end else if (cmd_i.rd_next) begin
      rd_idx_d = rd_idx_q + LIT_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_en_q  <= 1'b0;
      lit_len_q  <= '0;
      prev_q     <= '0;
      rep_q      <= '0;
      run_mode_q <= 1'b0;
      run_len_q  <= '0;
      emit_n_q   <= '0;
      rd_idx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        term_en_q <= cfg_wdata_i;
      end
      lit_len_q  <= lit_len_d;
      prev_q     <= prev_d;
      rep_q      <= rep_d;
      run_mode_q <= run_mode_d;
      run_len_q  <= run_len_d;
      emit_n_q   <= emit_n_d;
      rd_idx_q   <= rd_idx_d;
    end
  end

  // input transaction payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_byte_q <= data_byte_i;
      fin_q     <= final_byte_i;
    end
  end

  // literal store, one write and one registered read port
  assign rd_addr = cmd_i.rd_start ? '0 : rd_idx_q[LIT_AW-1:0];
  assign rd_en   = cmd_i.rd_start || cmd_i.rd_next;

  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      lit_mem[lit_len_q[LIT_AW-1:0]] <= in_byte_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= lit_mem[rd_addr];
    end
  end

  always_comb begin
    case (cmd_i.sel)
      SEL_RUN_CNT:  byte_o = 8'(run_len_q - RUN_W'(2));
      SEL_RUN_VAL:  byte_o = prev_q;
      SEL_LIT_HDR:  byte_o = LIT_HDR_BASE + 8'(emit_n_q) - 8'd1;
      SEL_LIT_DATA: byte_o = rd_data_q;
      SEL_ZERO:     byte_o = 8'h00;
      default:      byte_o = 8'h00;
    endcase
  end

  assign status_o.run_mode    = run_mode_q;
  assign status_o.match       = (in_byte_q == prev_q);
  assign status_o.run_below   = (run_len_q < RUN_W'(RUN_LIMIT));
  assign status_o.run_at_edge = (run_len_q == RUN_W'(RUN_LIMIT - 1));
  assign status_o.emit_zero   = (emit_n_q == '0);
  assign status_o.rd_last     = (rd_idx_q == emit_n_q);
  assign status_o.fin         = fin_q;
  assign status_o.term_en     = term_en_q;

endmodule

// ===== rtl/rlle_pack.sv =====
// byte packer and output register: gathers encoded bytes into result words
// depends on rlle_pkg; takes push and done commands from rlle_ctrl
module rlle_pack (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rlle_pkg::pack_cmd_t   cmd_i,
  input  logic [7:0]            byte_i,
  output rlle_pkg::pack_status_t status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [63:0]           out_word_o,
  output logic [3:0]            out_count_o,
  output logic                  run_end_o,
  output logic                  stream_done_o
);
  import rlle_pkg::*;

  logic [OUT_BYTES*8-1:0] acc_q, acc_d;
  logic [OUT_CW-1:0]      cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [63:0]            word_q;
  logic [3:0]             count_q;
  logic                   run_end_q, stream_done_q;
  logic                   out_free, full, send;
  logic [OUT_LW-1:0]      lane;

  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (cnt_q == OUT_CW'(OUT_BYTES));
  assign send     = (cmd_i.push && full) || (cmd_i.done && cnt_q != '0);
  assign lane     = cnt_q[OUT_LW-1:0];

  assign status_o.can_push = !full || out_free;
  assign status_o.can_done = (cnt_q == '0) || out_free;

  always_comb begin
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.push) begin
      if (full) begin
        // full word leaves only once more bytes are known to follow
        acc_d       = '0;
        acc_d[7:0]  = byte_i;
        cnt_d       = OUT_CW'(1);
      end else begin
        acc_d[8*lane +: 8] = byte_i;
        cnt_d              = cnt_q + OUT_CW'(1);
      end
    end
    if (cmd_i.done) begin
      acc_d = '0;
      cnt_d = '0;
    end
    if (send) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (send) begin
      word_q        <= 64'(acc_q);
      count_q       <= 4'(cnt_q);
      run_end_q     <= cmd_i.done;
      stream_done_q <= cmd_i.done && cmd_i.fin;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_word_o    = word_q;
  assign out_count_o   = count_q;
  assign run_end_o     = run_end_q;
  assign stream_done_o = stream_done_q;

endmodule

// ===== rtl/rlle_ctrl.sv =====
// encoder controller: sequences one input transaction through run, literal
// and flush emission; depends on rlle_pkg, drives rlle_dp and rlle_pack
module rlle_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  rlle_pkg::dp_status_t   dp_i,
  output rlle_pkg::dp_cmd_t      dp_o,
  input  rlle_pkg::pack_status_t pk_i,
  output rlle_pkg::pack_cmd_t    pk_o
);
  import rlle_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_STEP     = 10'b00_0000_0010,
    S_RUN_HI   = 10'b00_0000_0100,
    S_RUN_LO   = 10'b00_0000_1000,
    S_ADD      = 10'b00_0001_0000,
    S_LIT_HDR  = 10'b00_0010_0000,
    S_LIT_BODY = 10'b00_0100_0000,
    S_FIN      = 10'b00_1000_0000,
    S_TERM     = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   fin_phase_q, fin_phase_d;
  logic   add_pend_q, add_pend_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    fin_phase_d = fin_phase_q;
    add_pend_d  = add_pend_q;
    dp_o        = '0;
    dp_o.sel    = SEL_ZERO;
    pk_o        = '0;
    pk_o.fin    = dp_i.fin;

    case (state_q)
      S_IDLE: begin
        fin_phase_d = 1'b0;
        if (in_valid_i) begin
          dp_o.load_in = 1'b1;
          state_d      = S_STEP;
        end
      end
      S_STEP: begin
        if (dp_i.run_mode && dp_i.match && dp_i.run_below) begin
          dp_o.run_inc = 1'b1;
          add_pend_d   = 1'b0;
          state_d      = dp_i.run_at_edge ? S_RUN_HI : S_FIN;
        end else if (dp_i.run_mode) begin
          add_pend_d = 1'b1;
          state_d    = S_RUN_HI;
        end else begin
          dp_o.add = 1'b1;
          state_d  = S_LIT_HDR;
        end
      end
      S_RUN_HI: begin
        dp_o.sel = SEL_RUN_CNT;
        if (pk_i.can_push) begin
          pk_o.push = 1'b1;
          state_d   = S_RUN_LO;
        end
      end
      S_RUN_LO: begin
        dp_o.sel = SEL_RUN_VAL;
        if (pk_i.can_push) begin
          pk_o.push      = 1'b1;
          dp_o.run_clear = 1'b1;
          if (fin_phase_q) begin
            state_d = S_TERM;
          end else if (add_pend_q) begin
            state_d = S_ADD;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_ADD: begin
        dp_o.add = 1'b1;
        state_d  = S_LIT_HDR;
      end
      S_LIT_HDR: begin
        dp_o.sel = SEL_LIT_HDR;
        if (dp_i.emit_zero) begin
          if (fin_phase_q) begin
            state_d = S_TERM;
          end else if (!dp_i.fin && pk_i.can_done) begin
            pk_o.done = 1'b1;
            state_d   = S_IDLE;
          end else begin
            state_d = S_FIN;
          end
        end else if (pk_i.can_push) begin
          pk_o.push     = 1'b1;
          dp_o.rd_start = 1'b1;
          state_d       = S_LIT_BODY;
        end
      end
      S_LIT_BODY: begin
        dp_o.sel = SEL_LIT_DATA;
        if (pk_i.can_push) begin
          pk_o.push    = 1'b1;
          dp_o.rd_next = 1'b1;
          if (dp_i.rd_last) begin
            state_d = fin_phase_q ? S_TERM : S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!dp_i.fin) begin
          if (pk_i.can_done) begin
            pk_o.done = 1'b1;
            state_d   = S_IDLE;
          end
        end else begin
          fin_phase_d = 1'b1;
          if (dp_i.run_mode) begin
            state_d = S_RUN_HI;
          end else begin
            dp_o.load_flush = 1'b1;
            state_d         = S_LIT_HDR;
          end
        end
      end
      S_TERM: begin
        dp_o.sel = SEL_ZERO;
        if (!dp_i.term_en) begin
          dp_o.final_clear = 1'b1;
          state_d          = S_DONE;
        end else if (pk_i.can_push) begin
          pk_o.push        = 1'b1;
          dp_o.final_clear = 1'b1;
          state_d          = S_DONE;
        end
      end
      S_DONE: begin
        if (pk_i.can_done) begin
          pk_o.done = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fin_phase_q <= 1'b0;
      add_pend_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      fin_phase_q <= fin_phase_d;
      add_pend_q  <= add_pend_d;
    end
  end

endmodule
